@@ src/bdl_pkg.sv @@
// Package for the bounded double-ended list: command and status codes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package bdl_pkg;

  // Fixed field widths of the transaction ports
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ITEM_W      = 32;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned COUNT_OUT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_t;

  // Sequencer states: idle, execute, three memory reads, capture, present result
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_HD,
    S_TL,
    S_FIN,
    S_OUT
  } state_t;

  // Which element the memory read port fetches this cycle
  typedef enum logic [1:0] {
    SEL_READ,
    SEL_HEAD,
    SEL_TAIL
  } rd_sel_t;

  typedef struct packed {
    logic    load_in;   // latch the input transaction
    logic    exec;      // update pointers, write memory, set status
    rd_sel_t rd_sel;    // read port address select
    logic    cap_read;  // capture read element from memory output
    logic    cap_head;  // capture head element
    logic    cap_tail;  // capture tail element
  } ctrl_t;

endpackage

`default_nettype wire

@@ src/bounded_double_ended_list_top.sv @@
// Top level of the bounded double-ended list: controller plus datapath.
// Depends on bdl_pkg, bdl_ctrl and bdl_dpath.
`default_nettype none

// Bounded deque of DEPTH element words in a circular buffer. Each command
// (insert head, insert tail, remove head, remove tail, read at index) gives
// one result with status, count after the command, the element read and the
// head and tail elements. One command is in flight at a time and passes
// from acceptance to out_valid through one execute state, then three reads
// through the single registered read port of the element memory (read
// element, head, tail), then a capture state. The result holds until taken;
// the controller is idle again the cycle after, so a new command is accepted
// only once the previous result has been taken. No clearing pass is needed
// after reset; slots are only read once written.
module bounded_double_ended_list_top
  import bdl_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic [ITEM_W-1:0]       in_item_value,
  input  wire logic [IDX_W-1:0]        in_read_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [STAT_W-1:0]       out_status,
  output logic      [COUNT_OUT_W-1:0]  out_entry_count,
  output logic      [ITEM_W-1:0]       out_read_value,
  output logic      [ITEM_W-1:0]       out_head_value,
  output logic      [ITEM_W-1:0]       out_tail_value
);

  ctrl_t ctrl;

  bdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  bdl_dpath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_cmd          (in_cmd),
    .in_item_value   (in_item_value),
    .in_read_index   (in_read_index),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value),
    .out_head_value  (out_head_value),
    .out_tail_value  (out_tail_value)
  );

endmodule

`default_nettype wire

@@ src/bdl_ctrl.sv @@
// Controller of the bounded double-ended list: sequences one command
// through execute, memory reads and result hand-off. Depends on bdl_pkg.
`default_nettype none

module bdl_ctrl
  import bdl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output ctrl_t      ctrl
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_RD;
      S_RD:   state_nxt = S_HD;
      S_HD:   state_nxt = S_TL;
      S_TL:   state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctrl          = '0;
    ctrl.rd_sel   = SEL_HEAD;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load_in = in_valid;
      end
      S_EXEC: ctrl.exec = 1'b1;
      S_RD:   ctrl.rd_sel = SEL_READ;
      S_HD: begin
        ctrl.rd_sel   = SEL_HEAD;
        ctrl.cap_read = 1'b1;
      end
      S_TL: begin
        ctrl.rd_sel   = SEL_TAIL;
        ctrl.cap_head = 1'b1;
      end
      S_FIN:  ctrl.cap_tail = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/bdl_dpath.sv @@
// Datapath of the bounded double-ended list: circular buffer memory,
// head pointer, element count and result registers. Depends on bdl_pkg.
`default_nettype none

module bdl_dpath
  import bdl_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctrl_t                   ctrl,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic [ITEM_W-1:0]       in_item_value,
  input  wire logic [IDX_W-1:0]        in_read_index,
  output logic      [STAT_W-1:0]       out_status,
  output logic      [COUNT_OUT_W-1:0]  out_entry_count,
  output logic      [ITEM_W-1:0]       out_read_value,
  output logic      [ITEM_W-1:0]       out_head_value,
  output logic      [ITEM_W-1:0]       out_tail_value
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned CW_W  = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  // Physical slot at an offset from a base slot, with one wrap
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Latched transaction
  logic [CMD_W-1:0]      cmd_r;
  logic [ITEM_W-1:0]     item_r;
  logic [IDX_W-1:0]      idx_r;

  // List state
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  stat_t                 status_r, status_nxt;

  // Memory
  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_q;
  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [PTR_W-1:0]      raddr;

  // Result registers
  logic [ELEM_WIDTH-1:0] read_r, headv_r, tailv_r;

  logic                  full;
  logic                  empty;
  logic [CNT_W-1:0]      last;
  logic [CMP_W-1:0]      idx_ext, last_ext, clamp;
  logic [PTR_W-1:0]      rd_off, tl_off;
  logic [CW_W-1:0]       count_ext;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r  <= in_cmd;
      item_r <= in_item_value;
      idx_r  <= in_read_index;
    end
  end

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Command execution
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    we         = 1'b0;
    waddr      = head_r;
    case (cmd_r)
      CMD_INS_HEAD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - PTR_W'(1);
          waddr     = head_nxt;
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_INS_TAIL: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          waddr     = slot_of(head_r, count_r[PTR_W-1:0]);
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REM_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = slot_of(head_r, PTR_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_REM_TAIL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (empty) status_nxt = ST_EMPTY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_DONE;
    end else if (ctrl.exec) begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // Read offsets: clamped read index and tail, zero when empty
  assign last     = count_r - CNT_W'(1);
  assign idx_ext  = CMP_W'(idx_r);
  assign last_ext = CMP_W'(last);
  assign clamp    = (idx_ext > last_ext) ? last_ext : idx_ext;
  assign rd_off   = empty ? '0 : PTR_W'(clamp);
  assign tl_off   = empty ? '0 : last[PTR_W-1:0];

  always_comb begin
    unique case (ctrl.rd_sel)
      SEL_READ: raddr = slot_of(head_r, rd_off);
      SEL_HEAD: raddr = head_r;
      SEL_TAIL: raddr = slot_of(head_r, tl_off);
      default:  raddr = head_r;
    endcase
  end

  // Element memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.exec && we) begin
      mem[waddr] <= ELEM_WIDTH'(item_r);
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[raddr];
  end

  // Result capture, zero where the element does not exist
  always_ff @(posedge clk) begin
    if (ctrl.cap_read) begin
      read_r <= (cmd_r == CMD_READ && !empty) ? mem_q : '0;
    end
    if (ctrl.cap_head) begin
      headv_r <= empty ? '0 : mem_q;
    end
    if (ctrl.cap_tail) begin
      tailv_r <= empty ? '0 : mem_q;
    end
  end

  assign count_ext       = CW_W'(count_r);
  assign out_status      = status_r;
  assign out_entry_count = count_ext[COUNT_OUT_W-1:0];
  assign out_read_value  = ITEM_W'(read_r);
  assign out_head_value  = ITEM_W'(headv_r);
  assign out_tail_value  = ITEM_W'(tailv_r);

endmodule

`default_nettype wire

@@ bench/bounded_double_ended_list_top_tb.sv @@
// Testbench for bounded_double_ended_list_top: drives list commands over the
// valid/ready input channel and checks every result against a built-in model
// of the circular-buffer deque. Depends on bdl_pkg and the RTL only.
module bounded_double_ended_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdl_pkg::*;

  localparam int unsigned LIST_DEPTH   = 256;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RST_CYCLES   = 5;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned SETTLE_CYCLES = 12;

  // Command codes the block does not define; they must leave the list alone
  localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = CMD_READ + 3'd1;
  localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = '1;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [COUNT_OUT_W-1:0] count;
    logic [ITEM_W-1:0]      read_val;
    logic [ITEM_W-1:0]      head_val;
    logic [ITEM_W-1:0]      tail_val;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_cmd = '0;
  logic [ITEM_W-1:0]      in_item_value = '0;
  logic [IDX_W-1:0]       in_read_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STAT_W-1:0]      out_status;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic [ITEM_W-1:0]      out_read_value;
  logic [ITEM_W-1:0]      out_head_value;
  logic [ITEM_W-1:0]      out_tail_value;

  // Model state of the deque
  logic [ITEM_W-1:0]      list_store [LIST_DEPTH];
  logic [IDX_W-1:0]       list_head = '0;
  logic [COUNT_OUT_W-1:0] list_count = '0;

  list_result_t pending_results [$];
  list_result_t want_res;
  int unsigned  fail_cnt = 0;
  int unsigned  tx_idle_pct = 34;
  int unsigned  rx_idle_pct = 50;
  logic         hold_req = 1'b0;

  bounded_double_ended_list_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_item_value   (in_item_value),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value),
    .out_head_value  (out_head_value),
    .out_tail_value  (out_tail_value)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one command to the model deque and return the result it yields
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] op,
                                                  input logic [ITEM_W-1:0] val,
                                                  input logic [IDX_W-1:0] idx);
    list_result_t           res;
    logic [COUNT_OUT_W-1:0] pos;
    res = '0;
    res.status = ST_DONE;
    case (op)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (op == CMD_INS_HEAD) begin
          list_head = list_head - 1'b1;
          list_store[list_head] = val;
          list_count = list_count + 1'b1;
        end else begin
          list_store[IDX_W'(list_head + list_count[IDX_W-1:0])] = val;
          list_count = list_count + 1'b1;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == CMD_REM_HEAD) list_head = list_head + 1'b1;
          list_count = list_count - 1'b1;
        end
      end
      CMD_READ: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // index past the tail reads the tail
          pos = (COUNT_OUT_W'(idx) > list_count - 1'b1) ? list_count - 1'b1
                                                         : COUNT_OUT_W'(idx);
          res.read_val = list_store[IDX_W'(list_head + pos[IDX_W-1:0])];
        end
      end
      default: ;
    endcase
    res.count = list_count;
    if (list_count != 0) begin
      res.head_val = list_store[list_head];
      res.tail_val = list_store[IDX_W'(list_head + list_count[IDX_W-1:0] - 1'b1)];
    end
    return res;
  endfunction

  // Offer one transaction, wait for acceptance, record its expected result
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ITEM_W-1:0] val,
                          input logic [IDX_W-1:0] idx);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= op;
    in_item_value <= val;
    in_read_index <= idx;
    // inputs only move at rising edges, so the falling-edge view holds at the next edge
    do begin
      @(negedge clk);
      took = (in_ready === 1'b1);
      @(posedge clk);
    end while (!took);
    pending_results.push_back(apply_list_cmd(op, val, idx));
  endtask

  // Element words lean toward the extremes now and then
  function automatic logic [ITEM_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(1)) return IDX_W'($urandom_range(255));
    return IDX_W'($urandom_range(list_count));
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert();
    return $urandom_range(1) ? CMD_INS_TAIL : CMD_INS_HEAD;
  endfunction

  function automatic logic [CMD_W-1:0] pick_remove();
    return $urandom_range(1) ? CMD_REM_TAIL : CMD_REM_HEAD;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : rx_stall
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [ITEM_W-1:0] want,
                                      input logic [ITEM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Result checker: a transaction seen at the falling edge completes at the next rise
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no command outstanding");
        fail_cnt++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("status", ITEM_W'(want_res.status), ITEM_W'(out_status));
        check_field("entry_count", ITEM_W'(want_res.count), ITEM_W'(out_entry_count));
        check_field("read_value", want_res.read_val, out_read_value);
        check_field("head_value", want_res.head_val, out_head_value);
        check_field("tail_value", want_res.tail_val, out_tail_value);
      end
    end
  end

  // Removes, reads and undefined codes on a fresh, empty list
  task automatic test_empty_list();
    send_cmd(CMD_READ, '1, 8'hFF);
    send_cmd(CMD_REM_HEAD, '0, '0);
    send_cmd(CMD_REM_TAIL, '1, '0);
    send_cmd(CMD_FIRST_SPARE, '1, 8'hFF);
    send_cmd(CMD_LAST_SPARE, '0, '0);
  endtask

  // Each operation once or more, extreme words, clamped and in-range reads
  task automatic test_basic_ops();
    send_cmd(CMD_INS_HEAD, '0, 8'hFF);
    send_cmd(CMD_INS_TAIL, '1, '0);
    send_cmd(CMD_INS_HEAD, 32'hA5A5_5A5A, '0);
    send_cmd(CMD_INS_TAIL, 32'h1234_5678, '0);
    send_cmd(CMD_READ, '1, 8'd0);
    send_cmd(CMD_READ, '0, 8'd1);
    send_cmd(CMD_READ, '0, 8'd3);
    send_cmd(CMD_READ, '0, 8'd4);   // index equal to count
    send_cmd(CMD_READ, '0, 8'hFF);
    send_cmd(CMD_LAST_SPARE - 3'd1, '1, 8'd2);
    send_cmd(CMD_REM_HEAD, '1, '0);
    send_cmd(CMD_REM_TAIL, '0, '0);
    send_cmd(CMD_READ, '0, 8'd1);
    send_cmd(CMD_REM_TAIL, '0, '0);
    send_cmd(CMD_REM_HEAD, '0, '0);  // last element out
    send_cmd(CMD_REM_HEAD, '0, '0);
    send_cmd(CMD_READ, '0, '0);
  endtask

  // Fill to capacity from both ends, then push against the full list
  task automatic test_fill_to_capacity();
    while (list_count < LIST_DEPTH) begin
      if ($urandom_range(7) == 0) send_cmd(CMD_READ, $urandom, pick_index());
      else send_cmd(pick_insert(), pick_word(), IDX_W'($urandom_range(255)));
    end
    repeat (6) send_cmd(pick_insert(), pick_word(), IDX_W'($urandom_range(255)));
    send_cmd(CMD_READ, '0, 8'hFF);
    send_cmd(CMD_READ, '0, 8'h00);
  endtask

  // Drain from both ends, then remove and read past empty
  task automatic test_drain_to_empty();
    while (list_count != 0) begin
      if ($urandom_range(7) == 0) send_cmd(CMD_READ, $urandom, pick_index());
      else send_cmd(pick_remove(), $urandom, IDX_W'($urandom_range(255)));
    end
    send_cmd(CMD_REM_TAIL, $urandom, '0);
    send_cmd(CMD_REM_HEAD, $urandom, '0);
    send_cmd(CMD_READ, $urandom, IDX_W'($urandom_range(255)));
  endtask

  // Receiver holds off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (10) begin
      if ($urandom_range(2) == 0) send_cmd(CMD_READ, $urandom, pick_index());
      else send_cmd(pick_insert(), pick_word(), IDX_W'($urandom_range(255)));
    end
  endtask

  // Weighted random mix of all commands
  task automatic test_random_mix(input int unsigned n_cmds);
    int unsigned roll;
    repeat (n_cmds) begin
      roll = $urandom_range(99);
      if (roll < 40)
        send_cmd(pick_insert(), pick_word(), IDX_W'($urandom_range(255)));
      else if (roll < 65)
        send_cmd(pick_remove(), $urandom, IDX_W'($urandom_range(255)));
      else if (roll < 94)
        send_cmd(CMD_READ, $urandom, pick_index());
      else
        send_cmd(3'($urandom_range(CMD_FIRST_SPARE, CMD_LAST_SPARE)), $urandom,
                 IDX_W'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 34;
    rx_idle_pct = 50;
    test_empty_list();
    test_basic_ops();
    test_fill_to_capacity();

    tx_idle_pct = 50;
    rx_idle_pct = 34;
    test_drain_to_empty();
    test_random_mix(20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_mix(60);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
